// File: rtl/irf_pkg.sv
// irf_pkg: shared types and constants for the index record fixup block
// holds the input and result payload structs, status codes and header positions
// no dependencies
`timescale 1ns / 1ps

package irf_pkg;

  // word position counter saturates at its all-ones value
  localparam int unsigned POS_W = 13;
  localparam logic [POS_W-1:0] POS_LIMIT = 13'd8191;

  // header word positions
  localparam logic [POS_W-1:0] POS_MAGIC_LO   = 13'd0;
  localparam logic [POS_W-1:0] POS_MAGIC_HI   = 13'd1;
  localparam logic [POS_W-1:0] POS_SEQ_OFFSET = 13'd2;
  localparam logic [POS_W-1:0] POS_SEQ_COUNT  = 13'd3;
  localparam logic [POS_W-1:0] POS_FIRST_BODY = 13'd4;
  localparam logic [POS_W-1:0] POS_ENTRY_LO   = 13'd14;
  localparam logic [POS_W-1:0] POS_ENTRY_HI   = 13'd15;
  localparam logic [POS_W-1:0] POS_ALLOC_LO   = 13'd16;
  localparam logic [POS_W-1:0] POS_ALLOC_HI   = 13'd17;

  // "IN" and "DX" as little-endian words
  localparam logic [15:0] MAGIC_LO = 16'h4E49;
  localparam logic [15:0] MAGIC_HI = 16'h5844;

  // length fields are stored relative to the header
  localparam logic [31:0] HEADER_SKIP = 32'h0000_0018;

  // smallest legal sequence word offset
  localparam logic [14:0] SEQ_MIN_OFFSET = 15'd4;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_MAGIC  = 2'd1,
    ST_BAD_LENGTH = 2'd2,
    ST_TORN       = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [15:0] word_out;
    logic        replaced;
    logic [1:0]  status;
    logic        end_of_record;
  } out_t;

endpackage

// File: rtl/index_record_fixup.sv
// index_record_fixup: streaming update sequence fixup for index records
// top level; uses irf_pkg for payload types, status codes and header positions
`timescale 1ns / 1ps

// Takes one 16-bit record word per cycle unless stalled and returns one result
// word per input word, in the next cycle. All header checks, capture of the
// check and replacement words and the sector tail compare are done in the cycle
// of the input transfer; the result sits in an output register, and a new word
// is taken in the same cycle that the held result is taken, so the sustained
// rate is one word per clock. Replacement words live in a small memory with a
// registered read, launched at the sector tail word. Status is sticky within a
// record and final on the result flagged end_of_record.
module index_record_fixup
  import irf_pkg::*;
#(
  parameter int unsigned MAX_SECTORS  = 16,
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned SECTOR_WORDS = SECTOR_BYTES / 2;
  localparam int unsigned SW_W   = $clog2(SECTOR_WORDS);
  localparam int unsigned SIDX_W = $clog2(int'(POS_LIMIT) / SECTOR_WORDS + 1);
  localparam int unsigned SF_W   = $clog2(MAX_SECTORS + 1);
  localparam int unsigned IDX_W  = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

  // record state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SW_W-1:0]   sec_word_q, sec_word_d;
  logic [SIDX_W-1:0] sec_idx_q, sec_idx_d;
  logic [14:0]       seq_off_q, seq_off_d;
  logic [SF_W-1:0]   sectors_q, sectors_d;
  logic [15:0]       check_q, check_d;
  logic [31:0]       entry_len_q, entry_len_d;
  logic [15:0]       alloc_lo_q, alloc_lo_d;
  logic              stopped_q, stopped_d;
  status_e           status_q, status_d;

  // output stage
  logic              out_valid_q;
  logic [15:0]       out_word_q;
  logic              out_rep_q;
  status_e           out_status_q;
  logic              out_eor_q;
  logic [15:0]       rd_data_q;

  // replacement word store
  logic [15:0]       repl_mem [MAX_SECTORS];

  logic              in_fire;
  logic              active;
  logic              is_tail;
  logic              rep;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [15:0]       cnt_m1;
  logic [31:0]       alloc_full;
  logic [15:0]       pos_ext;
  status_e           status_hdr;
  status_e           status_new;

  // accept while the output register is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign active  = (pos_q != POS_LIMIT) && (status_q == ST_OK);
  assign is_tail = (sec_word_q == SW_W'(SECTOR_WORDS - 1));
  assign pos_ext = 16'(pos_q);
  assign cnt_m1  = in_i.word - 16'd1;
  assign rd_addr = IDX_W'(sec_idx_q);

  // header decode, capture and sector tail fixup
  always_comb begin
    seq_off_d   = seq_off_q;
    sectors_d   = sectors_q;
    check_d     = check_q;
    entry_len_d = entry_len_q;
    alloc_lo_d  = alloc_lo_q;
    stopped_d   = stopped_q;
    status_hdr  = status_q;
    alloc_full  = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    rep         = 1'b0;

    if (active) begin
      case (pos_q)
        POS_MAGIC_LO: begin
          if (in_i.word != MAGIC_LO) status_hdr = ST_BAD_MAGIC;
        end
        POS_MAGIC_HI: begin
          if (in_i.word != MAGIC_HI) status_hdr = ST_BAD_MAGIC;
        end
        POS_SEQ_OFFSET: begin
          seq_off_d = in_i.word[15:1];
        end
        POS_SEQ_COUNT: begin
          if (in_i.word == 16'd0 || 32'(cnt_m1) > 32'(MAX_SECTORS) ||
              seq_off_q < SEQ_MIN_OFFSET ||
              (17'(seq_off_q) + 17'(cnt_m1)) > 17'(SECTOR_WORDS - 2)) begin
            status_hdr = ST_BAD_LENGTH;
          end else begin
            sectors_d = SF_W'(cnt_m1);
          end
        end
        POS_ENTRY_LO: begin
          entry_len_d = {16'd0, in_i.word};
        end
        POS_ENTRY_HI: begin
          entry_len_d = {in_i.word, entry_len_q[15:0]} + HEADER_SKIP;
        end
        POS_ALLOC_LO: begin
          alloc_lo_d = in_i.word;
        end
        POS_ALLOC_HI: begin
          alloc_full = {in_i.word, alloc_lo_q} + HEADER_SKIP;
          if (alloc_full < 32'(sectors_q) * 32'(SECTOR_BYTES)) status_hdr = ST_BAD_LENGTH;
        end
        default: begin
        end
      endcase

      // check word and replacement word capture
      if (status_hdr == ST_OK && pos_q >= POS_FIRST_BODY) begin
        if (pos_ext == 16'(seq_off_q)) begin
          check_d = in_i.word;
        end else if (pos_ext > 16'(seq_off_q) &&
                     pos_ext <= 16'(seq_off_q) + 16'(sectors_q)) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(pos_ext - 16'(seq_off_q) - 16'd1);
        end
      end
    end

    status_new = status_hdr;

    // sector tail compare
    if (active && status_hdr == ST_OK && !stopped_q && is_tail &&
        32'(sec_idx_q) < 32'(sectors_q)) begin
      if (in_i.word == check_q) begin
        rep = 1'b1;
      end else begin
        stopped_d = 1'b1;
        if (32'(sec_idx_q) * 32'(SECTOR_BYTES) <= entry_len_q) status_new = ST_TORN;
      end
    end

    // record ended inside the header
    if (in_i.last && status_new == ST_OK && pos_q < POS_ALLOC_HI) begin
      status_new = ST_BAD_LENGTH;
    end
    status_d = status_new;
  end

  // position and in-sector counters
  always_comb begin
    pos_d      = pos_q;
    sec_word_d = sec_word_q;
    sec_idx_d  = sec_idx_q;
    if (pos_q != POS_LIMIT) begin
      pos_d = pos_q + 1'b1;
      if (is_tail) begin
        sec_word_d = '0;
        sec_idx_d  = sec_idx_q + 1'b1;
      end else begin
        sec_word_d = sec_word_q + 1'b1;
      end
    end
  end

  // record state registers, cleared after the last word of a record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sec_word_q  <= '0;
      sec_idx_q   <= '0;
      seq_off_q   <= '0;
      sectors_q   <= '0;
      check_q     <= '0;
      entry_len_q <= '0;
      alloc_lo_q  <= '0;
      stopped_q   <= 1'b0;
      status_q    <= ST_OK;
    end else if (in_fire) begin
      if (in_i.last) begin
        pos_q       <= '0;
        sec_word_q  <= '0;
        sec_idx_q   <= '0;
        seq_off_q   <= '0;
        sectors_q   <= '0;
        check_q     <= '0;
        entry_len_q <= '0;
        alloc_lo_q  <= '0;
        stopped_q   <= 1'b0;
        status_q    <= ST_OK;
      end else begin
        pos_q       <= pos_d;
        sec_word_q  <= sec_word_d;
        sec_idx_q   <= sec_idx_d;
        seq_off_q   <= seq_off_d;
        sectors_q   <= sectors_d;
        check_q     <= check_d;
        entry_len_q <= entry_len_d;
        alloc_lo_q  <= alloc_lo_d;
        stopped_q   <= stopped_d;
        status_q    <= status_d;
      end
    end
  end

  // replacement word memory, registered read at the sector tail
  always_ff @(posedge clk_i) begin
    if (in_fire && wr_en) repl_mem[wr_addr] <= in_i.word;
    if (in_fire && rep) rd_data_q <= repl_mem[rd_addr];
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_word_q   <= in_i.word;
      out_rep_q    <= rep;
      out_status_q <= status_d;
      out_eor_q    <= in_i.last;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_o.word_out       = out_rep_q ? rd_data_q : out_word_q;
  assign out_o.replaced       = out_rep_q;
  assign out_o.status         = out_status_q;
  assign out_o.end_of_record  = out_eor_q;

  // a replaced word never carries an error status
  a_rep_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.replaced |-> out_o.status == ST_OK)
    else $error("replaced word with nonzero status");

  // the last word of a record restarts the position count
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.last |=> pos_q == '0 && status_q == ST_OK && !stopped_q)
    else $error("record state not cleared after last word");

  // fixups can only stop in a record that has sectors to fix
  a_stop_sectors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> sectors_q != '0)
    else $error("fixups stopped without sectors");

  // sector counters follow the word position
  a_sector_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == '0 |-> sec_word_q == '0 && sec_idx_q == '0)
    else $error("sector counters out of step");

endmodule
